FILE: src/assert_macros.svh
// Assertion macros used by the cache top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Assert a property under the given clock and active-low reset.
`define DMSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Assert that a condition never holds.
`define DMSC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define DMSC_ASSERT(lbl, clk, rst_n, prop)
`define DMSC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: src/dmsc_pkg.sv
// Types and constants of the direct-mapped search cache.
`timescale 1ns / 1ps
package dmsc_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;
  localparam int unsigned GEN_W      = 6;
  localparam int unsigned IBITS_W    = 5;
  localparam int unsigned OCC_W      = 17;
  localparam int unsigned TAG_LSB    = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_GENERATION = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 1'b1;

  localparam logic [IBITS_W-1:0] MIN_INDEX_BITS   = 5'd10;
  localparam logic [IBITS_W-1:0] RESET_INDEX_BITS = 5'd16;
  localparam logic [OCC_W-1:0]   OCC_MAX          = '1;

  localparam logic [1:0] BND_NONE  = 2'd0;
  localparam logic [1:0] BND_UPPER = 2'd1;
  localparam logic [1:0] BND_LOWER = 2'd2;
  localparam logic [1:0] BND_EXACT = 2'd3;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_STORE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW
  } state_e;

  typedef struct packed {
    logic [15:0]        tag;
    logic [15:0]        move;
    logic signed [15:0] score;
    logic signed [7:0]  depth;
    logic [GEN_W-1:0]   gen;
    logic [1:0]         bound;
  } entry_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [63:0]        key;
    logic [15:0]        move_in;
    logic signed [15:0] score_in;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic signed [7:0]  depth_in;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [15:0]        move_out;
    logic signed [15:0] score_out;
    logic signed [7:0]  depth_out;
    logic [1:0]         bound_out;
    logic [GEN_W-1:0]   generation_out;
    logic               written;
    logic [OCC_W-1:0]   occupied_count;
  } rsp_t;

endpackage

FILE: src/dmsc_stream_if.sv
// Valid/ready stream interface carrying one item of type T.
`timescale 1ns / 1ps
interface dmsc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/dmsc_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dmsc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/direct_mapped_search_cache.sv
// Direct-mapped search cache: top level.
// Usage:
//   req carries one item per handshake: op (probe, store, clear, nop), key and the
//   store payload. rsp returns exactly one result item per request item.
//   cfg_we_i/cfg_idx_i/cfg_data_i write generation (0) or index width (1);
//   write only while no item is in flight.
// Timing:
//   Probe and store: the entry is read from the single entry RAM on
//   acceptance and written back in the RMW state, when the result is
//   loaded into the output register; RMW holds while that register is full
//   and not taken. No new item is taken until that read-modify-write is done.
//   Clear runs a sweep over all 2**INDEX_BITS entries, one per cycle, and
//   then returns its result from the RMW state.
// Reset and reconfiguration:
//   After reset, and after a write of the index width, the same sweep runs
//   with req.ready low; config writes still land.
// Back-pressure:
//   An item is accepted while a result still waits in the output register;
//   its write-back holds until rsp.ready frees that register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module direct_mapped_search_cache #(
  parameter int unsigned INDEX_BITS   = 16,
  parameter int unsigned DEPTH_MARGIN = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  dmsc_stream_if.sink                    req,
  dmsc_stream_if.source                  rsp,
  input  logic                           cfg_we_i,
  input  logic [dmsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmsc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dmsc_pkg::*;

  localparam int unsigned DEPTH = 2 ** INDEX_BITS;
  localparam int unsigned CNT_W = (INDEX_BITS + 1 > OCC_W) ? INDEX_BITS + 1 : OCC_W;
  localparam logic [IBITS_W-1:0] MAX_BITS = IBITS_W'(INDEX_BITS);

  state_e                  state_q, state_d;
  req_t                    item_q, item_d;
  logic [INDEX_BITS-1:0]   idx_q, idx_d;
  logic [INDEX_BITS-1:0]   clr_addr_q, clr_addr_d;
  logic                    clr_reply_q, clr_reply_d;
  logic [GEN_W-1:0]        gen_q, gen_d;
  logic [IBITS_W-1:0]      ibits_q, ibits_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d, cnt_next;
  rsp_t                    rsp_q, rsp_d;
  logic                    out_valid_q, out_valid_d;

  logic [IBITS_W-1:0]      eff_bits;
  logic [INDEX_BITS-1:0]   idx_mask;
  logic [INDEX_BITS-1:0]   in_idx;
  logic                    req_fire, rmw_fire, clr_last;
  logic                    cfg_gen_wr, cfg_ibits_wr;
  logic                    rmw_start;

  logic                    ram_we, ram_re;
  logic [INDEX_BITS-1:0]   ram_waddr;
  logic [63:0]             ram_wdata, ram_rdata;

  entry_t                  old_e, new_e;
  logic                    old_valid, tag_match, do_write;
  logic [1:0]              new_bound;
  logic signed [15:0]      d_new, d_old_m;
  rsp_t                    result;

  assign cfg_gen_wr   = cfg_we_i && (cfg_idx_i == CFG_GENERATION);
  assign cfg_ibits_wr = cfg_we_i && (cfg_idx_i == CFG_INDEX_BITS);

  // Effective index width and mask
  always_comb begin
    if (ibits_q < MIN_INDEX_BITS) begin
      eff_bits = MIN_INDEX_BITS;
    end else if (ibits_q > MAX_BITS) begin
      eff_bits = MAX_BITS;
    end else begin
      eff_bits = ibits_q;
    end
    for (int i = 0; i < INDEX_BITS; i++) begin
      idx_mask[i] = (IBITS_W'(i) < eff_bits);
    end
  end

  assign in_idx = req.data.key[INDEX_BITS-1:0] & idx_mask;

  // Store decision on the entry read back
  assign old_e     = entry_t'(ram_rdata);
  assign old_valid = (old_e.bound != BND_NONE);
  assign tag_match = old_valid && (old_e.tag == item_q.key[63:TAG_LSB]);
  assign d_new     = 16'($signed(item_q.depth_in));
  assign d_old_m   = 16'($signed(old_e.depth)) - 16'(DEPTH_MARGIN);

  always_comb begin
    if ($signed(item_q.score_in) <= $signed(item_q.alpha)) begin
      new_bound = BND_UPPER;
    end else if ($signed(item_q.score_in) >= $signed(item_q.beta)) begin
      new_bound = BND_LOWER;
    end else begin
      new_bound = BND_EXACT;
    end
    if (tag_match) begin
      do_write = !($signed(item_q.depth_in) < $signed(old_e.depth));
    end else begin
      do_write = !(old_valid && (old_e.gen == gen_q) && (d_new <= d_old_m));
    end
  end

  always_comb begin
    new_e.tag   = item_q.key[63:TAG_LSB];
    new_e.move  = item_q.move_in;
    new_e.score = item_q.score_in;
    new_e.depth = item_q.depth_in;
    new_e.gen   = gen_q;
    new_e.bound = new_bound;
  end

  // Result item
  always_comb begin
    result   = '0;
    cnt_next = cnt_q;
    case (item_q.op)
      OP_PROBE: begin
        if (tag_match) begin
          result.hit            = 1'b1;
          result.move_out       = old_e.move;
          result.score_out      = old_e.score;
          result.depth_out      = old_e.depth;
          result.bound_out      = old_e.bound;
          result.generation_out = old_e.gen;
        end
      end
      OP_STORE: begin
        result.written = do_write;
        if (do_write && !old_valid) begin
          cnt_next = cnt_q + CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        cnt_next = '0;
      end
      default: begin
      end
    endcase
    if (cnt_next > CNT_W'(OCC_MAX)) begin
      result.occupied_count = OCC_MAX;
    end else begin
      result.occupied_count = cnt_next[OCC_W-1:0];
    end
  end

  // Handshake and RAM control
  always_comb begin
    req.ready = (state_q == ST_IDLE);
    req_fire  = req.valid && (state_q == ST_IDLE);
    rmw_fire  = (state_q == ST_RMW) && (!out_valid_q || rsp.ready);
    clr_last  = (state_q == ST_CLEAR) && (clr_addr_q == '1);
    ram_re    = req_fire;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = rmw_fire && (item_q.op == OP_STORE) && do_write;
      ram_waddr = idx_q;
      ram_wdata = new_e;
    end
  end

  assign rmw_start = req_fire && (req.data.op != OP_CLEAR) && !cfg_ibits_wr;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = clr_reply_q ? ST_RMW : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req.data.op == OP_CLEAR) ? ST_CLEAR : ST_RMW;
        end
      end
      ST_RMW: begin
        if (rmw_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
    if (cfg_ibits_wr) begin
      state_d = ST_CLEAR;
    end
  end

  // Register next values
  always_comb begin
    item_d      = req_fire ? req.data : item_q;
    idx_d       = req_fire ? in_idx : idx_q;
    clr_addr_d  = (state_q == ST_CLEAR) ? clr_addr_q + 1'b1 : '0;
    clr_reply_d = clr_reply_q;
    gen_d       = gen_q;
    ibits_d     = ibits_q;
    cnt_d       = cnt_q;
    rsp_d       = rmw_fire ? result : rsp_q;
    out_valid_d = rmw_fire || (out_valid_q && !rsp.ready);

    if (req_fire && (req.data.op == OP_CLEAR)) begin
      clr_reply_d = 1'b1;
      gen_d       = '0;
      cnt_d       = '0;
    end
    if (rmw_fire) begin
      clr_reply_d = 1'b0;
      cnt_d       = cnt_next;
    end
    if (cfg_gen_wr) begin
      gen_d = cfg_data_i[GEN_W-1:0];
    end
    if (cfg_ibits_wr) begin
      ibits_d     = cfg_data_i[IBITS_W-1:0];
      gen_d       = '0;
      cnt_d       = '0;
      clr_addr_d  = '0;
      clr_reply_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      clr_reply_q <= 1'b0;
      gen_q       <= '0;
      ibits_q     <= RESET_INDEX_BITS;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      clr_reply_q <= clr_reply_d;
      gen_q       <= gen_d;
      ibits_q     <= ibits_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    rsp_q  <= rsp_d;
  end

  assign rsp.valid = out_valid_q;
  assign rsp.data  = rsp_q;

  dmsc_ram #(
    .WIDTH (64),
    .DEPTH (DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  `DMSC_ASSERT_NEVER(a_no_idle_write, clk_i, rst_ni, ram_we && (state_q == ST_IDLE))
  `DMSC_ASSERT(a_accept_to_rmw, clk_i, rst_ni, rmw_start |=> state_q == ST_RMW)
  `DMSC_ASSERT(a_rsp_from_rmw, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_RMW)
  `DMSC_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= CNT_W'(DEPTH))

endmodule

FILE: tb/sv/direct_mapped_search_cache_tb.sv
// Testbench of the direct-mapped search cache: directed and random items against a predictor.
`timescale 1ns / 1ps
module direct_mapped_search_cache_tb;
  import dmsc_pkg::*;

  localparam int unsigned TABLE_BITS   = 16;
  localparam int          MARGIN       = 4;
  localparam int          STALL_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 16;
  localparam int          PRINT_CAP    = 40;
  localparam int          POOL_SIZE    = 24;

  localparam logic [63:0] KEY_A  = 64'hFFFF_8000_0000_0001;
  localparam logic [63:0] KEY_A2 = 64'h1234_0000_0000_0001;
  localparam logic [63:0] KEY_B  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] KEY_C  = 64'h5A5A_0000_0000_8000;
  localparam logic [63:0] KEY_D  = 64'hABCD_0000_0000_03FF;
  localparam logic [63:0] KEY_D2 = 64'hABCD_0000_0000_13FF;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dmsc_stream_if #(.T(req_t)) req_if ();
  dmsc_stream_if #(.T(rsp_t)) rsp_if ();

  direct_mapped_search_cache #(
    .INDEX_BITS  (TABLE_BITS),
    .DEPTH_MARGIN(MARGIN)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  entry_t             cache_mem [0:(1 << TABLE_BITS)-1];
  int unsigned        occ_count;
  logic [GEN_W-1:0]   cur_gen;
  logic [IBITS_W-1:0] index_width;

  rsp_t        awaited_rsp [$];
  int unsigned err_count = 0;
  int unsigned idle_pct  = 19;
  logic [63:0] key_pool [POOL_SIZE];

  function automatic void wipe_cache();
    foreach (cache_mem[i]) cache_mem[i] = '0;
    occ_count = 0;
    cur_gen   = '0;
  endfunction

  function automatic rsp_t cache_response(req_t it);
    rsp_t        r;
    entry_t      e;
    entry_t      n;
    logic [15:0] slot;
    int unsigned width;
    int          old_depth;
    int          new_depth;
    logic        same_tag;
    logic        do_write;
    logic [1:0]  bnd;
    width = index_width;
    if (width < MIN_INDEX_BITS) width = MIN_INDEX_BITS;
    if (width > TABLE_BITS) width = TABLE_BITS;
    slot      = 16'(it.key & ((64'd1 << width) - 64'd1));
    e         = cache_mem[slot];
    same_tag  = (e.bound != BND_NONE) && (e.tag == it.key[63:TAG_LSB]);
    old_depth = $signed(e.depth);
    new_depth = $signed(it.depth_in);
    r = '0;
    case (it.op)
      OP_PROBE: begin
        if (same_tag) begin
          r.hit            = 1'b1;
          r.move_out       = e.move;
          r.score_out      = e.score;
          r.depth_out      = e.depth;
          r.bound_out      = e.bound;
          r.generation_out = e.gen;
        end
      end
      OP_STORE: begin
        if ($signed(it.score_in) <= $signed(it.alpha)) bnd = BND_UPPER;
        else if ($signed(it.score_in) >= $signed(it.beta)) bnd = BND_LOWER;
        else bnd = BND_EXACT;
        if (same_tag) begin
          do_write = new_depth >= old_depth;
        end else begin
          do_write = !(e.bound != BND_NONE && e.gen == cur_gen &&
                       new_depth <= old_depth - MARGIN);
        end
        if (do_write) begin
          if (e.bound == BND_NONE) occ_count++;
          n.tag   = it.key[63:TAG_LSB];
          n.move  = it.move_in;
          n.score = it.score_in;
          n.depth = it.depth_in;
          n.gen   = cur_gen;
          n.bound = bnd;
          cache_mem[slot] = n;
          r.written = 1'b1;
        end
      end
      OP_CLEAR: wipe_cache();
      default: ;
    endcase
    r.occupied_count = (occ_count > OCC_MAX) ? OCC_MAX : OCC_W'(occ_count);
    return r;
  endfunction

  function automatic req_t make_item(op_e op, logic [63:0] key, logic [15:0] mv,
                                     int sc, int al, int be, int dp);
    req_t it;
    it.op       = op;
    it.key      = key;
    it.move_in  = mv;
    it.score_in = 16'(sc);
    it.alpha    = 16'(al);
    it.beta     = 16'(be);
    it.depth_in = 8'(dp);
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("%0t tb: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic send_item(req_t it);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk_i); while (!req_if.ready);
    awaited_rsp.push_back(cache_response(it));
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_GENERATION) begin
      cur_gen = val[GEN_W-1:0];
    end else if (idx == CFG_INDEX_BITS) begin
      index_width = val[IBITS_W-1:0];
      wipe_cache();
    end
    @(posedge clk_i);
  endtask

  // Keys share few slots and tags, some aliasing only at narrow index widths
  task automatic build_pool();
    logic [15:0] tags  [4];
    logic [9:0]  bases [3];
    logic [5:0]  hi;
    foreach (tags[i]) tags[i] = 16'($urandom);
    foreach (bases[i]) bases[i] = 10'($urandom);
    hi = 6'($urandom_range(63, 1));
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = {tags[i % 4], 32'($urandom), (i >= 12) ? hi : 6'd0, bases[(i / 4) % 3]};
    end
  endtask

  function automatic req_t random_item();
    int   roll;
    int   al;
    op_e  op;
    roll = $urandom_range(99);
    if (roll < 8) begin
      case ($urandom_range(2))
        0: op = OP_PROBE;
        1: op = OP_STORE;
        default: op = OP_NOP;
      endcase
      return make_item(op, {$urandom, $urandom}, 16'($urandom), int'($urandom),
                       int'($urandom), int'($urandom), int'($urandom));
    end
    op = (roll < 50) ? OP_STORE : OP_PROBE;
    if ($urandom_range(9) == 0)
      return make_item(op, key_pool[$urandom_range(POOL_SIZE - 1)], 16'($urandom),
                       int'($urandom), int'($urandom), int'($urandom), int'($urandom));
    al = int'($urandom_range(200)) - 100;
    return make_item(op, key_pool[$urandom_range(POOL_SIZE - 1)], 16'($urandom),
                     al + int'($urandom_range(70)) - 20, al,
                     al + int'($urandom_range(50)) - 10, int'($urandom_range(16)) - 8);
  endfunction

  task automatic test_empty_probe();
    send_item(make_item(OP_PROBE, 64'd0, 16'd0, 0, 0, 0, 0));
    send_item(make_item(OP_PROBE, '1, 16'd0, 0, 0, 0, 0));
  endtask

  task automatic test_store_bounds();
    send_item(make_item(OP_STORE, KEY_A, 16'hFFFF, -32768, -32768, 32767, 127));
    send_item(make_item(OP_PROBE, KEY_A, 16'd0, 0, 0, 0, 0));
    send_item(make_item(OP_STORE, KEY_B, 16'h0000, 32767, -32768, 32767, -128));
    send_item(make_item(OP_STORE, KEY_C, 16'h1234, 0, -1, 1, 0));
    send_item(make_item(OP_PROBE, KEY_B, 16'd0, 0, 0, 0, 0));
    send_item(make_item(OP_PROBE, KEY_C, 16'd0, 0, 0, 0, 0));
    send_item(make_item(OP_PROBE, KEY_A2, 16'd0, 0, 0, 0, 0));
  endtask

  task automatic test_replacement();
    // same tag: shallower refused, equal depth taken
    send_item(make_item(OP_STORE, KEY_A, 16'h0101, 5, 0, 10, 126));
    send_item(make_item(OP_STORE, KEY_A, 16'h0202, 5, 0, 10, 127));
    // other tag: kept while current generation and deeper by the margin
    send_item(make_item(OP_STORE, KEY_A2, 16'h0303, 5, 0, 10, 123));
    send_item(make_item(OP_STORE, KEY_A2, 16'h0404, 5, 0, 10, 124));
    wait_idle();
    write_reg(CFG_GENERATION, 6'd63);
    // other tag in a stale generation: always replaced
    send_item(make_item(OP_STORE, KEY_A, 16'h0505, 5, 0, 10, -128));
    send_item(make_item(OP_PROBE, KEY_A, 16'd0, 0, 0, 0, 0));
  endtask

  task automatic test_nop_and_clear();
    send_item(make_item(OP_NOP, KEY_A, 16'hFFFF, -1, -1, -1, -1));
    send_item(make_item(OP_CLEAR, KEY_A, 16'd0, 0, 0, 0, 0));
    send_item(make_item(OP_PROBE, KEY_A, 16'd0, 0, 0, 0, 0));
    send_item(make_item(OP_STORE, KEY_A, 16'h0606, 0, -5, 5, 3));
  endtask

  task automatic test_index_width();
    wait_idle();
    write_reg(CFG_INDEX_BITS, 6'd0);
    send_item(make_item(OP_STORE, KEY_D, 16'h0707, 1, 0, 2, 9));
    send_item(make_item(OP_PROBE, KEY_D2, 16'd0, 0, 0, 0, 0));
    wait_idle();
    write_reg(CFG_INDEX_BITS, 6'd31);
    send_item(make_item(OP_STORE, KEY_D, 16'h0808, 1, 0, 2, 9));
    send_item(make_item(OP_PROBE, KEY_D2, 16'd0, 0, 0, 0, 0));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      case (phase)
        3: write_reg(CFG_INDEX_BITS, 6'd10);
        6: write_reg(CFG_INDEX_BITS, 6'd13);
        9: write_reg(CFG_INDEX_BITS, 6'd16);
        default: ;
      endcase
      write_reg(CFG_GENERATION, 6'($urandom_range(63)));
      build_pool();
      idle_pct = (phase == 5) ? 0 : 19;
      for (int n = 0; n < 119; n++) begin
        if ((phase == 4 || phase == 8) && n == 60)
          send_item(make_item(OP_CLEAR, {$urandom, $urandom}, 16'd0, 0, 0, 0, 0));
        else
          send_item(random_item());
      end
    end
    idle_pct = 19;
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (awaited_rsp.size() == 0) begin
        report_mismatch("unexpected result item", 32'(got.occupied_count), 32'd0);
      end else begin
        want = awaited_rsp.pop_front();
        check_field("hit", 32'(got.hit), 32'(want.hit));
        check_field("move_out", 32'(got.move_out), 32'(want.move_out));
        check_field("score_out", 32'(got.score_out), 32'(want.score_out));
        check_field("depth_out", 32'(got.depth_out), 32'(want.depth_out));
        check_field("bound_out", 32'(got.bound_out), 32'(want.bound_out));
        check_field("generation_out", 32'(got.generation_out), 32'(want.generation_out));
        check_field("written", 32'(got.written), 32'(want.written));
        check_field("occupied_count", 32'(got.occupied_count), 32'(want.occupied_count));
      end
    end
  end

  // Clearing sweeps hold off request handshakes
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_GENERATION;
    cfg_data_i   <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    wipe_cache();
    index_width = RESET_INDEX_BITS;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_probe();
    test_store_bounds();
    test_replacement();
    test_nop_and_clear();
    test_index_width();
    test_random_traffic();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && awaited_rsp.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/dmsc_pkg.sv
src/dmsc_stream_if.sv
src/dmsc_ram.sv
src/direct_mapped_search_cache.sv
tb/sv/direct_mapped_search_cache_tb.sv
